FILE: hw/rtl/dpt_pkg.sv
// ----------------------------------------------------------------------------
// dpt_pkg
// Shared types, constants and the torque map for the dual pedal torque block.
// ----------------------------------------------------------------------------
package dpt_pkg;

  localparam int ANGLE_W  = 14;
  localparam int POS_W    = 10;
  localparam int PCT_W    = 7;
  localparam int TQ_W     = 10;
  localparam int PROD_W   = ANGLE_W + POS_W;
  localparam int CFG_W    = 16;
  localparam int CFG_AW   = 3;

  localparam int SENSOR_FULL = 16383;
  localparam int POS_FULL    = 1000;
  localparam int TABLE_LEN   = 16;
  localparam int SPAN        = POS_FULL / (TABLE_LEN - 1);

  // reciprocal of the table span, 2^21 / 66, for the interpolation divide
  localparam int RECIP_SH   = 21;
  localparam int RECIP_SPAN = (1 << RECIP_SH) / SPAN;
  localparam int RECIP_W    = 15;
  localparam int FRAC_W     = 7;
  localparam int IP_W       = 13;
  localparam int IQ_W       = IP_W + RECIP_W;
  localparam int POS15_W    = 14;

  // position / 10 as (pos * 205) >> 11, exact for 0..1000
  localparam int PCT_MUL = 205;
  localparam int PCT_SH  = 11;
  localparam int PCT_PW  = POS_W + 8;

  localparam logic [TQ_W-1:0] LIMP_LIMIT = 10'd300;

  localparam logic [TQ_W-1:0] TORQUE_TABLE [TABLE_LEN] = '{
    10'd0,   10'd0,   10'd33,  10'd100, 10'd200, 10'd300, 10'd400, 10'd467,
    10'd533, 10'd600, 10'd667, 10'd733, 10'd800, 10'd867, 10'd933, 10'd1000
  };

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    FAULT_NONE     = 3'd0,
    FAULT_READ_ONE = 3'd1,
    FAULT_READ_TWO = 3'd2,
    FAULT_IMPLAUS  = 3'd3,
    FAULT_STUCK    = 3'd4
  } fault_t;

  typedef enum logic [2:0] {
    VS_INIT      = 3'd0,
    VS_RUN       = 3'd1,
    VS_DEGRADED  = 3'd2,
    VS_LIMP      = 3'd3,
    VS_SAFE_STOP = 3'd4,
    VS_SHUTDOWN  = 3'd5
  } vstate_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_RAMP_LIMIT     = 3'd0,
    REG_PLAUS_THRESH   = 3'd1,
    REG_PLAUS_DEBOUNCE = 3'd2,
    REG_STUCK_THRESH   = 3'd3,
    REG_STUCK_CYCLES   = 3'd4,
    REG_LATCH_CLEAR    = 3'd5,
    REG_LIMIT_RUN      = 3'd6,
    REG_LIMIT_DEGRADED = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [TQ_W-1:0]    ramp_limit;
    logic [ANGLE_W-1:0] plaus_threshold;
    logic [7:0]         plaus_debounce;
    logic [ANGLE_W-1:0] stuck_threshold;
    logic [15:0]        stuck_cycles;
    logic [7:0]         latch_clear_cycles;
    logic [TQ_W-1:0]    limit_run;
    logic [TQ_W-1:0]    limit_degraded;
  } cfg_t;

  // classified item handed from the front part to the back part
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [PCT_W-1:0] pct;
    fault_t           fault;
    logic [2:0]       vst;
    logic [TQ_W-1:0]  map;
  } item_t;

endpackage

FILE: hw/rtl/dpt_front.sv
// ----------------------------------------------------------------------------
// dpt_front
// Accepts sensor items, runs the fault checks and computes position and the
// mapped torque through a short pipeline that feeds the item queue.
// ----------------------------------------------------------------------------
module dpt_front (
  input  logic                        clk,
  input  logic                        rst,
  input  dpt_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dpt_pkg::ANGLE_W-1:0] angle_one,
  input  logic [dpt_pkg::ANGLE_W-1:0] angle_two,
  input  logic                        read_ok_one,
  input  logic                        read_ok_two,
  input  logic [2:0]                  veh_mode,
  input  logic                        pop,
  output logic                        push,
  output dpt_pkg::item_t              push_item
);
  import dpt_pkg::*;

  logic                acc;
  logic [OCC_W-1:0]    occ, occ_next;

  // check state
  logic [ANGLE_W-1:0]  last_angle_one;
  logic [7:0]          implausible_count, implausible_count_next;
  logic [15:0]         unchanged_count, unchanged_count_next;

  logic                ok_both;
  fault_t              fault0;
  logic [ANGLE_W-1:0]  diff_pair, diff_last;
  logic [7:0]          imp_inc;
  logic [15:0]         unch_inc;
  logic [ANGLE_W:0]    angle_sum;
  logic [PROD_W-1:0]   prod0;

  // stage 1: scaled product
  logic                s1_valid;
  logic [PROD_W-1:0]   s1_prod;
  fault_t              s1_fault;
  logic [2:0]          s1_vst;
  logic [POS_W-1:0]    q_hi, pos1;
  logic [ANGLE_W:0]    q_rem;

  // stage 2: position
  logic                s2_valid;
  logic [POS_W-1:0]    s2_pos;
  fault_t              s2_fault;
  logic [2:0]          s2_vst;
  logic [POS15_W-1:0]  pos15;
  logic [3:0]          idx;
  logic [POS_W-1:0]    seg_base;
  logic [FRAC_W-1:0]   frac, rise;
  logic [IP_W-1:0]     ip_prod;
  logic [PCT_PW-1:0]   pct_prod;

  // stage 3: table point and interpolation product
  logic                s3_valid;
  logic [POS_W-1:0]    s3_pos;
  logic [PCT_W-1:0]    s3_pct;
  fault_t              s3_fault;
  logic [2:0]          s3_vst;
  logic [TQ_W-1:0]     s3_lo;
  logic [IP_W-1:0]     s3_p;
  logic                s3_full;
  logic [IQ_W-1:0]     iq_prod;
  logic [FRAC_W-1:0]   iq0;
  logic [IP_W-1:0]     iq_rem;
  logic [TQ_W:0]       interp;
  logic [TQ_W-1:0]     map3;

  // items in flight or queued; never more than the queue holds
  assign acc      = in_valid && in_ready;
  assign in_ready = (occ < OCC_W'(FIFO_DEPTH));
  assign occ_next = occ + OCC_W'(acc) - OCC_W'(pop);

  always_comb begin
    ok_both   = read_ok_one && read_ok_two;
    diff_pair = (angle_one >= angle_two) ? angle_one - angle_two : angle_two - angle_one;
    diff_last = (angle_one >= last_angle_one) ? angle_one - last_angle_one
                                              : last_angle_one - angle_one;
    imp_inc   = (implausible_count == 8'hFF) ? implausible_count : implausible_count + 8'd1;
    unch_inc  = (unchanged_count == 16'hFFFF) ? unchanged_count : unchanged_count + 16'd1;

    implausible_count_next = implausible_count;
    unchanged_count_next   = unchanged_count;

    if (!read_ok_one) begin
      fault0 = FAULT_READ_ONE;
    end else if (!read_ok_two) begin
      fault0 = FAULT_READ_TWO;
    end else begin
      fault0 = FAULT_NONE;
    end

    if (fault0 == FAULT_NONE) begin
      if (diff_pair >= cfg.plaus_threshold) begin
        implausible_count_next = imp_inc;
        if (imp_inc >= cfg.plaus_debounce) fault0 = FAULT_IMPLAUS;
      end else begin
        implausible_count_next = '0;
      end
    end

    if (fault0 == FAULT_NONE) begin
      if (diff_last < cfg.stuck_threshold) begin
        unchanged_count_next = unch_inc;
        if (unch_inc >= cfg.stuck_cycles) fault0 = FAULT_STUCK;
      end else begin
        unchanged_count_next = '0;
      end
    end

    angle_sum = {1'b0, angle_one} + {1'b0, angle_two};
    prod0     = ok_both ? {{POS_W{1'b0}}, angle_sum[ANGLE_W:1]} * PROD_W'(POS_FULL) : '0;
  end

  // x / 16383: x = q*16384 + lo = q*16383 + (lo + q), remainder below twice the divisor
  always_comb begin
    q_hi  = s1_prod[PROD_W-1:ANGLE_W];
    q_rem = {1'b0, s1_prod[ANGLE_W-1:0]} + (ANGLE_W+1)'(q_hi);
    pos1  = q_hi + POS_W'(q_rem >= (ANGLE_W+1)'(SENSOR_FULL));
  end

  always_comb begin
    pos15 = {{(POS15_W-POS_W){1'b0}}, s2_pos} * POS15_W'(TABLE_LEN - 1);
    idx   = '0;
    for (int k = 1; k < TABLE_LEN; k++) begin
      if (pos15 >= POS15_W'(k * POS_FULL)) idx = idx + 4'd1;
    end
    seg_base = POS_W'(idx) * POS_W'(SPAN);
    frac     = FRAC_W'(s2_pos - seg_base);
    rise     = FRAC_W'(TORQUE_TABLE[idx + 4'd1] - TORQUE_TABLE[idx]);
    ip_prod  = {{(IP_W-FRAC_W){1'b0}}, rise} * {{(IP_W-FRAC_W){1'b0}}, frac};
    pct_prod = PCT_PW'(s2_pos) * PCT_PW'(PCT_MUL);
  end

  // p / 66 by reciprocal, at most one short, then one correction
  always_comb begin
    iq_prod = IQ_W'(s3_p) * IQ_W'(RECIP_SPAN);
    iq0     = iq_prod[IQ_W-1:RECIP_SH];
    iq_rem  = s3_p - IP_W'(iq0) * IP_W'(SPAN);
    interp  = (TQ_W+1)'(s3_lo) + (TQ_W+1)'(iq0)
            + (TQ_W+1)'(iq_rem >= IP_W'(SPAN));
    if (s3_full || interp > (TQ_W+1)'(POS_FULL)) begin
      map3 = TQ_W'(POS_FULL);
    end else begin
      map3 = interp[TQ_W-1:0];
    end
  end

  assign push            = s3_valid;
  assign push_item.pos   = s3_pos;
  assign push_item.pct   = s3_pct;
  assign push_item.fault = s3_fault;
  assign push_item.vst   = s3_vst;
  assign push_item.map   = map3;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ               <= '0;
      last_angle_one    <= '0;
      implausible_count <= '0;
      unchanged_count   <= '0;
      s1_valid          <= 1'b0;
      s2_valid          <= 1'b0;
      s3_valid          <= 1'b0;
    end else begin
      occ      <= occ_next;
      s1_valid <= acc;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      if (acc) begin
        last_angle_one    <= angle_one;
        implausible_count <= implausible_count_next;
        unchanged_count   <= unchanged_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_prod  <= prod0;
    s1_fault <= fault0;
    s1_vst   <= veh_mode;
    s2_pos   <= pos1;
    s2_fault <= s1_fault;
    s2_vst   <= s1_vst;
    s3_pos   <= s2_pos;
    s3_pct   <= pct_prod[PCT_SH+PCT_W-1:PCT_SH];
    s3_fault <= s2_fault;
    s3_vst   <= s2_vst;
    s3_lo    <= TORQUE_TABLE[idx];
    s3_p     <= ip_prod;
    s3_full  <= (s2_pos >= POS_W'(POS_FULL));
  end

endmodule

FILE: hw/rtl/dpt_fifo.sv
// ----------------------------------------------------------------------------
// dpt_fifo
// Item queue between the front and back parts.
// ----------------------------------------------------------------------------
module dpt_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dpt_pkg::item_t push_item,
  input  logic           pop,
  output logic           not_empty,
  output dpt_pkg::item_t head
);
  import dpt_pkg::*;

  item_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [OCC_W-1:0]   count;

  // front part holds off input before the queue can overflow
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FIFO_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + FIFO_AW'(1);
      count <= count + OCC_W'(push) - OCC_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

FILE: hw/rtl/dpt_back.sv
// ----------------------------------------------------------------------------
// dpt_back
// Applies ramp limit, state cap and the zero-torque latch, one item a cycle
// while the output takes them, and holds the result in the output register.
// ----------------------------------------------------------------------------
module dpt_back (
  input  logic                      clk,
  input  logic                      rst,
  input  dpt_pkg::cfg_t             cfg,
  input  logic                      head_valid,
  input  dpt_pkg::item_t            head,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [dpt_pkg::POS_W-1:0] out_pos,
  output logic [dpt_pkg::PCT_W-1:0] out_pct,
  output logic [2:0]                out_fault,
  output logic [dpt_pkg::TQ_W-1:0]  out_torque,
  output logic                      out_latch
);
  import dpt_pkg::*;

  logic [TQ_W-1:0] last_torque;
  logic            zero_latch, zero_latch_next;
  logic [7:0]      clear_count, clear_count_next;
  logic [7:0]      clr_inc;
  logic [TQ_W-1:0] tq_ramp, tq_cap, cap, tq_next;
  logic [TQ_W:0]   ramp_sum;

  assign pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    ramp_sum = {1'b0, last_torque} + {1'b0, cfg.ramp_limit};
    tq_ramp  = head.map;
    if (head.map > last_torque && (head.map - last_torque) > cfg.ramp_limit) begin
      tq_ramp = ramp_sum[TQ_W-1:0];
    end

    case (head.vst)
      VS_RUN:      cap = cfg.limit_run;
      VS_DEGRADED: cap = cfg.limit_degraded;
      VS_LIMP:     cap = LIMP_LIMIT;
      default:     cap = '0;
    endcase
    tq_cap = (tq_ramp > cap) ? cap : tq_ramp;

    clr_inc          = (clear_count == 8'hFF) ? clear_count : clear_count + 8'd1;
    zero_latch_next  = zero_latch;
    clear_count_next = clear_count;
    tq_next          = tq_cap;
    if (head.fault != FAULT_NONE) begin
      zero_latch_next  = 1'b1;
      clear_count_next = '0;
      tq_next          = '0;
    end else if (zero_latch) begin
      if (clr_inc >= cfg.latch_clear_cycles) begin
        zero_latch_next  = 1'b0;
        clear_count_next = '0;
      end else begin
        clear_count_next = clr_inc;
        tq_next          = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      last_torque <= '0;
      zero_latch  <= 1'b0;
      clear_count <= '0;
    end else begin
      if (pop) begin
        out_valid   <= 1'b1;
        last_torque <= tq_next;
        zero_latch  <= zero_latch_next;
        clear_count <= clear_count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_pos    <= head.pos;
      out_pct    <= head.pct;
      out_fault  <= head.fault;
      out_torque <= tq_next;
      out_latch  <= zero_latch_next;
    end
  end

endmodule

FILE: hw/rtl/dual_pedal_torque_request.sv
// ----------------------------------------------------------------------------
// dual_pedal_torque_request
// Redundant pedal sensor plausibility check with torque mapping.
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle and one result leaves per cycle while
// the output side takes them. Each item passes three stages that compute
// position and the interpolated map value, then the eight-entry queue and
// the back part, which feeds its registered torque and latch back into the
// next item. Input ready drops once eight items are in flight or queued, so
// a stalled output side throttles the input after nine items, one of them
// held in the output register. The user must write the registers through
// cfg_wen/cfg_addr/cfg_wdata only while the block is idle; the block itself
// does not enforce this.
module dual_pedal_torque_request (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // angle_one[13:0], angle_two[27:14], veh_mode[30:28], zero pad
  input  logic [31:0] s_axis_tdata,
  // read_ok_one[0], read_ok_two[1]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // position[9:0], position_percent[16:10], fault_code[19:17],
  // torque_request[29:20], zero pad
  output logic [31:0] m_axis_tdata,
  // latch_active[0]
  output logic [0:0]  m_axis_tuser
);
  import dpt_pkg::*;

  cfg_t             cfg;
  logic             push, pop, head_valid;
  item_t            push_item, head;
  logic [POS_W-1:0] out_pos;
  logic [PCT_W-1:0] out_pct;
  logic [2:0]       out_fault;
  logic [TQ_W-1:0]  out_torque;
  logic             out_latch;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ramp_limit         <= 10'd50;
      cfg.plaus_threshold    <= 14'd819;
      cfg.plaus_debounce     <= 8'd2;
      cfg.stuck_threshold    <= 14'd2;
      cfg.stuck_cycles       <= 16'd100;
      cfg.latch_clear_cycles <= 8'd50;
      cfg.limit_run          <= 10'd1000;
      cfg.limit_degraded     <= 10'd750;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_RAMP_LIMIT:     cfg.ramp_limit         <= cfg_wdata[TQ_W-1:0];
        REG_PLAUS_THRESH:   cfg.plaus_threshold    <= cfg_wdata[ANGLE_W-1:0];
        REG_PLAUS_DEBOUNCE: cfg.plaus_debounce     <= cfg_wdata[7:0];
        REG_STUCK_THRESH:   cfg.stuck_threshold    <= cfg_wdata[ANGLE_W-1:0];
        REG_STUCK_CYCLES:   cfg.stuck_cycles       <= cfg_wdata;
        REG_LATCH_CLEAR:    cfg.latch_clear_cycles <= cfg_wdata[7:0];
        REG_LIMIT_RUN:      cfg.limit_run          <= cfg_wdata[TQ_W-1:0];
        REG_LIMIT_DEGRADED: cfg.limit_degraded     <= cfg_wdata[TQ_W-1:0];
        default: ;
      endcase
    end
  end

  dpt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .angle_one     (s_axis_tdata[13:0]),
    .angle_two     (s_axis_tdata[27:14]),
    .read_ok_one   (s_axis_tuser[0]),
    .read_ok_two   (s_axis_tuser[1]),
    .veh_mode      (s_axis_tdata[30:28]),
    .pop           (pop),
    .push          (push),
    .push_item     (push_item)
  );

  dpt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .not_empty (head_valid),
    .head      (head)
  );

  dpt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_pos    (out_pos),
    .out_pct    (out_pct),
    .out_fault  (out_fault),
    .out_torque (out_torque),
    .out_latch  (out_latch)
  );

  assign m_axis_tdata = {2'b00, out_torque, out_fault, out_pct, out_pos};
  assign m_axis_tuser = out_latch;

endmodule

FILE: hw/rtl/dpt_checker.sv
// ----------------------------------------------------------------------------
// dpt_checker
// Port-level checks on the result stream of the pedal torque block.
// ----------------------------------------------------------------------------
module dpt_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);
  import dpt_pkg::*;

  logic [2:0]      fault;
  logic [TQ_W-1:0] torque;

  assign fault  = m_axis_tdata[19:17];
  assign torque = m_axis_tdata[29:20];

  // any fault sets the latch on the same item
  a_fault_latches: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (fault != FAULT_NONE) |-> m_axis_tuser[0])
    else $error("fault reported without latch");

  // a held latch forces zero torque
  a_latch_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> (torque == '0))
    else $error("torque nonzero while latched");

  // torque never above full scale, percent matches the position range
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (torque <= TQ_W'(POS_FULL))
                      && (m_axis_tdata[16:10] <= PCT_W'(100)))
    else $error("result out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind dual_pedal_torque_request dpt_checker u_dpt_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
